[hdl/calendar_to_unix_epoch_defines.svh]
// Assertion macros shared by the calendar to epoch converter.
// Depends on a clock named aclk and an active-low reset named aresetn in scope.
`ifndef CALENDAR_TO_UNIX_EPOCH_DEFINES_SVH
`define CALENDAR_TO_UNIX_EPOCH_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define C2UE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("calendar_to_unix_epoch: check failed");

// Consequent must hold in the cycle after the antecedent.
`define C2UE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("calendar_to_unix_epoch: check failed");

`endif

[hdl/c2ue_pkg.sv]
// Types, constants and month tables for the calendar to epoch converter.
// Used by every module of the block; depends on nothing.
package c2ue_pkg;

    localparam logic [13:0] YearFirst   = 14'd1970;
    localparam logic [13:0] YearLast    = 14'd2099;
    localparam logic [3:0]  MonthFeb    = 4'd2;
    localparam logic [15:0] DaysPerYear = 16'd365;
    localparam logic [16:0] SecsPerHour = 17'd3600;
    localparam logic [16:0] SecsPerMin  = 17'd60;
    localparam logic [32:0] SecsPerDay  = 33'd86400;

    typedef struct packed {
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day_of_month;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
    } date_t;

    typedef struct packed {
        logic        ok;
        logic        leap;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [15:0] days_year;
        logic [16:0] tod_secs;
    } stage1_t;

    typedef struct packed {
        logic        ok;
        logic [15:0] days;
        logic [16:0] tod_secs;
    } stage2_t;

    typedef struct packed {
        logic        epoch_valid;
        logic [31:0] epoch_seconds;
    } result_t;

    function automatic logic [4:0] month_len(input logic [3:0] idx);
        logic [4:0] len;
        case (idx)
            4'd1:                           len = 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:        len = 5'd30;
            default:                        len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] days_before(input logic [3:0] idx);
        logic [8:0] d;
        case (idx)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

[hdl/c2ue_check.sv]
// First pipeline stage: field range checks, whole-year day count, time of day.
// Depends on c2ue_pkg.
module c2ue_check (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  c2ue_pkg::date_t   in_date,
    output logic              out_valid,
    input  logic              out_ready,
    output c2ue_pkg::stage1_t out_data
);

    logic              valid_reg;
    c2ue_pkg::stage1_t data_reg;
    c2ue_pkg::stage1_t data_next;
    logic [13:0]       yoff_full;
    logic [7:0]        yoff;
    logic [7:0]        leap_sum;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        yoff_full = in_date.year - c2ue_pkg::YearFirst;
        yoff      = yoff_full[7:0];
        leap_sum  = yoff + 8'd1;
        data_next.ok = (in_date.year >= c2ue_pkg::YearFirst)
                    && (in_date.year <= c2ue_pkg::YearLast)
                    && (in_date.month >= 7'd1) && (in_date.month <= 7'd12)
                    && (in_date.day_of_month >= 7'd1) && (in_date.day_of_month <= 7'd31)
                    && (in_date.hour <= 7'd23) && (in_date.minute <= 7'd59)
                    && (in_date.second <= 7'd59);
        data_next.leap      = (in_date.year[1:0] == 2'b00);
        data_next.month     = in_date.month[3:0];
        data_next.day       = in_date.day_of_month[4:0];
        data_next.days_year = {8'h00, yoff} * c2ue_pkg::DaysPerYear
                            + {10'h000, leap_sum[7:2]};
        data_next.tod_secs  = {10'h000, in_date.hour} * c2ue_pkg::SecsPerHour
                            + {10'h000, in_date.minute} * c2ue_pkg::SecsPerMin
                            + {10'h000, in_date.second};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

[hdl/c2ue_days.sv]
// Second pipeline stage: month-length check and day count since the epoch.
// Depends on c2ue_pkg for the month tables.
module c2ue_days (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  c2ue_pkg::stage1_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output c2ue_pkg::stage2_t out_data
);

    logic              valid_reg;
    c2ue_pkg::stage2_t data_reg;
    c2ue_pkg::stage2_t data_next;
    logic [3:0]        idx;
    logic [4:0]        max_day;
    logic              leap_add;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        idx      = in_data.month - 4'd1;
        max_day  = (in_data.month == c2ue_pkg::MonthFeb && in_data.leap) ? 5'd29
                                                                         : c2ue_pkg::month_len(idx);
        leap_add = (in_data.month > c2ue_pkg::MonthFeb) && in_data.leap;
        data_next.ok       = in_data.ok && (in_data.day <= max_day);
        data_next.days     = in_data.days_year + {7'h00, c2ue_pkg::days_before(idx)}
                           + {15'h0000, leap_add} + {11'h000, in_data.day} - 16'd1;
        data_next.tod_secs = in_data.tod_secs;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

[hdl/c2ue_secs.sv]
// Third and fourth pipeline stages: days times seconds per day, then the final
// sum and the output register. Depends on c2ue_pkg.
module c2ue_secs (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  c2ue_pkg::stage2_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output c2ue_pkg::result_t out_data
);

    logic              mul_valid_reg;
    logic              mul_ok_reg;
    logic [31:0]       day_secs_reg;
    logic [16:0]       tod_reg;
    logic [32:0]       product;
    logic              mul_ready;
    logic              res_valid_reg;
    c2ue_pkg::result_t res_reg;
    c2ue_pkg::result_t res_next;
    logic [31:0]       sum;

    assign mul_ready = !res_valid_reg || out_ready;
    assign in_ready  = !mul_valid_reg || mul_ready;
    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

    assign product = {17'h00000, in_data.days} * c2ue_pkg::SecsPerDay;

    always_comb begin
        sum = day_secs_reg + {15'h0000, tod_reg};
        res_next.epoch_valid   = mul_ok_reg;
        res_next.epoch_seconds = mul_ok_reg ? sum : 32'h0000_0000;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                mul_valid_reg <= in_valid;
            end
            if (mul_ready) begin
                res_valid_reg <= mul_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            mul_ok_reg   <= in_data.ok;
            day_secs_reg <= product[31:0];
            tod_reg      <= in_data.tod_secs;
        end
        if (mul_ready && mul_valid_reg) begin
            res_reg <= res_next;
        end
    end

endmodule

[hdl/calendar_to_unix_epoch.sv]
// Calendar date and time to Unix epoch seconds, top level.
// Depends on c2ue_pkg, c2ue_check, c2ue_days, c2ue_secs and the defines header.
//
// Each beat on the s_ channel carries one date and time; each beat on the m_
// channel carries one result, in the same order, one result per input beat.
// A date from 1970 to 2099 with all fields in range gives the seconds since
// 1970-01-01 00:00:00 with m_tuser high; any other input gives zero seconds
// with m_tuser low.
// The block is a four-stage pipeline: range checks and year days, month days,
// the multiply by seconds per day, then the final sum in the output register.
// A beat passes through the check, days, multiply and output registers in turn,
// and m_tvalid rises once its result sits in the output register.
// Throughput is one beat per cycle while the receiver keeps m_tready high.
// When the receiver stalls, each stage still fills if its successor is empty;
// s_tready drops only once all four stages hold a beat.
// A synchronous low on aresetn empties the pipeline; no result is lost or
// repeated across a stall.
`include "calendar_to_unix_epoch_defines.svh"

module calendar_to_unix_epoch (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // year[13:0], month[20:14], day_of_month[27:21], hour[34:28],
    // minute[41:35], second[48:42], zero fill [55:49]
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // epoch_seconds[31:0]
    output logic [31:0] m_tdata,
    // valid_res[0]
    output logic        m_tuser
);

    c2ue_pkg::date_t   date;
    c2ue_pkg::stage1_t st1;
    c2ue_pkg::stage2_t st2;
    c2ue_pkg::result_t res;
    logic              v1;
    logic              v2;
    logic              r1;
    logic              r2;

    assign date.year         = s_tdata[13:0];
    assign date.month        = s_tdata[20:14];
    assign date.day_of_month = s_tdata[27:21];
    assign date.hour         = s_tdata[34:28];
    assign date.minute       = s_tdata[41:35];
    assign date.second       = s_tdata[48:42];

    c2ue_check u_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_date   (date),
        .out_valid (v1),
        .out_ready (r1),
        .out_data  (st1)
    );

    c2ue_days u_days (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v1),
        .in_ready  (r1),
        .in_data   (st1),
        .out_valid (v2),
        .out_ready (r2),
        .out_data  (st2)
    );

    c2ue_secs u_secs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v2),
        .in_ready  (r2),
        .in_data   (st2),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    assign m_tdata = res.epoch_seconds;
    assign m_tuser = res.epoch_valid;

    `C2UE_ASSERT_NOW(a_invalid_is_zero, m_tvalid && !m_tuser, m_tdata == 32'h0000_0000)
    `C2UE_ASSERT_NOW(a_epoch_in_range, m_tvalid && m_tuser, m_tdata <= 32'd4102444799)
    `C2UE_ASSERT_NOW(a_full_when_blocked, !s_tready, v1 && v2 && m_tvalid && !m_tready)

endmodule

[tb/calendar_to_unix_epoch_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for calendar_to_unix_epoch: directed and random dates are
// streamed in, and each result beat is compared against a local epoch calculation.
// Depends on c2ue_pkg and the calendar_to_unix_epoch RTL.
module calendar_to_unix_epoch_tb;

    localparam int RANDOM_DATES = 1580;
    localparam int HOLD_CYCLES  = 120;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;

    c2ue_pkg::date_t   dates_to_send[$];
    c2ue_pkg::result_t epochs_due[$];

    bit          in_beat;
    bit          out_beat;
    bit          hold_off;
    int          send_gap;
    int          stall_left;
    int unsigned total_dates;
    int unsigned beats_in;
    int unsigned results;
    int unsigned converted;
    int unsigned rejected;
    int unsigned input_stalls;
    int unsigned errors;

    calendar_to_unix_epoch dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic int month_length(int y, int mo);
        int len;
        case (mo)
            2: begin
                len = ((y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0))) ? 29 : 28;
            end
            4, 6, 9, 11: begin
                len = 30;
            end
            default: begin
                len = 31;
            end
        endcase
        return len;
    endfunction

    function automatic c2ue_pkg::result_t date_to_epoch(c2ue_pkg::date_t t);
        c2ue_pkg::result_t r;
        longint unsigned   days;
        r = '0;
        days = 0;
        if (t.year < c2ue_pkg::YearFirst || t.year > c2ue_pkg::YearLast ||
            t.month < 1 || t.month > 12 ||
            t.day_of_month < 1 || t.hour > 23 || t.minute > 59 || t.second > 59) begin
            return r;
        end
        if (t.day_of_month > month_length(t.year, t.month)) begin
            return r;
        end
        for (int y = c2ue_pkg::YearFirst; y < t.year; y++) begin
            days += (month_length(y, 2) == 29) ? 366 : 365;
        end
        for (int mo = 1; mo < t.month; mo++) begin
            days += month_length(t.year, mo);
        end
        days += t.day_of_month - 1;
        r.epoch_valid   = 1'b1;
        r.epoch_seconds = 32'(days * 86400 + t.hour * 3600 + t.minute * 60 + t.second);
        return r;
    endfunction

    task automatic add_date(int y, int mo, int d, int h, int mi, int s);
        c2ue_pkg::date_t t;
        t.year         = 14'(y);
        t.month        = 7'(mo);
        t.day_of_month = 7'(d);
        t.hour         = 7'(h);
        t.minute       = 7'(mi);
        t.second       = 7'(s);
        dates_to_send.push_back(t);
    endtask

    task automatic flag_error(string msg);
        if (errors < 10) begin
            $display("%0t: %s", $realtime, msg);
        end
        errors++;
    endtask

    // Sample both channels at the rising edge; predict on every accepted input beat.
    always @(posedge aclk) begin
        c2ue_pkg::date_t   seen;
        c2ue_pkg::result_t want;
        in_beat  = aresetn && s_tvalid && s_tready;
        out_beat = aresetn && m_tvalid && m_tready;
        if (aresetn && s_tvalid && !s_tready) begin
            input_stalls++;
        end
        if (in_beat) begin
            seen.year         = s_tdata[13:0];
            seen.month        = s_tdata[20:14];
            seen.day_of_month = s_tdata[27:21];
            seen.hour         = s_tdata[34:28];
            seen.minute       = s_tdata[41:35];
            seen.second       = s_tdata[48:42];
            epochs_due.push_back(date_to_epoch(seen));
            beats_in++;
        end
        if (out_beat) begin
            results++;
            if (epochs_due.size() == 0) begin
                flag_error($sformatf("result beat with nothing expected: seconds %0d valid %0b",
                                     m_tdata, m_tuser));
            end else begin
                want = epochs_due.pop_front();
                if (want.epoch_valid) begin
                    converted++;
                end else begin
                    rejected++;
                end
                if (m_tdata !== want.epoch_seconds || m_tuser !== want.epoch_valid) begin
                    flag_error($sformatf("result %0d: expected seconds %0d valid %0b, got %0d %0b",
                                         results, want.epoch_seconds, want.epoch_valid,
                                         m_tdata, m_tuser));
                end
            end
        end
    end

    always @(negedge aclk) begin
        c2ue_pkg::date_t next;
        if (aresetn) begin
            if (in_beat) begin
                send_gap = (((beats_in / 100) % 5) == 4) ? 0 : $urandom_range(0, 15);
            end
            if (!s_tvalid || in_beat) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (dates_to_send.size() > 0) begin
                    next = dates_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {7'd0, next.second, next.minute, next.hour,
                                 next.day_of_month, next.month, next.year};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (out_beat) begin
                stall_left = (((results / 100) % 5) == 2) ? 0 : $urandom_range(0, 15);
            end
            if (hold_off) begin
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Long receiver hold-offs so the pipeline fills and pushes back on the input.
    initial begin
        hold_off = 1'b0;
        wait (beats_in >= 400);
        @(posedge aclk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off = 1'b0;
        wait (beats_in >= 1200);
        @(posedge aclk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("FAIL calendar_to_unix_epoch");
        $finish;
    end

    initial begin
        c2ue_pkg::date_t t;
        int              kind;
        aclk     = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        send_gap   = 0;
        stall_left = 0;

        add_date(1970, 1, 1, 0, 0, 0);
        add_date(2099, 12, 31, 23, 59, 59);
        add_date(1969, 12, 31, 23, 59, 59);
        add_date(2100, 1, 1, 0, 0, 0);
        add_date(0, 0, 0, 0, 0, 0);
        add_date(16383, 127, 127, 127, 127, 127);
        add_date(9999, 99, 99, 99, 99, 99);
        add_date(2000, 0, 15, 12, 0, 0);
        add_date(2000, 13, 15, 12, 0, 0);
        add_date(2000, 6, 0, 12, 0, 0);
        add_date(2000, 1, 32, 12, 0, 0);
        add_date(2000, 6, 15, 24, 0, 0);
        add_date(2000, 6, 15, 23, 60, 0);
        add_date(2000, 6, 15, 23, 59, 60);
        add_date(2000, 2, 29, 1, 2, 3);
        add_date(2001, 2, 29, 1, 2, 3);
        add_date(2024, 2, 29, 23, 59, 59);
        add_date(2024, 2, 30, 0, 0, 0);
        add_date(2023, 4, 31, 0, 0, 0);
        add_date(2000, 3, 1, 0, 0, 0);
        add_date(2000, 12, 31, 23, 59, 59);
        add_date(2038, 1, 19, 3, 14, 8);

        for (int i = 0; i < RANDOM_DATES; i++) begin
            kind           = $urandom_range(0, 99);
            t.year         = 14'($urandom_range(1970, 2099));
            t.month        = 7'($urandom_range(1, 12));
            t.day_of_month = 7'($urandom_range(1, month_length(t.year, t.month)));
            t.hour         = 7'($urandom_range(0, 23));
            t.minute       = 7'($urandom_range(0, 59));
            t.second       = 7'($urandom_range(0, 59));
            if (kind < 10) begin
                t.month        = 7'd2;
                t.day_of_month = 7'($urandom_range(28, 29));
            end else if (kind < 25) begin
                case ($urandom_range(0, 5))
                    0: begin
                        t.year = $urandom_range(0, 1) ? 14'($urandom_range(2100, 16383))
                                                      : 14'($urandom_range(0, 1969));
                    end
                    1: begin
                        t.month = $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(13, 127));
                    end
                    2: begin
                        t.day_of_month = $urandom_range(0, 1) ? 7'd0 :
                            7'($urandom_range(month_length(t.year, t.month) + 1, 127));
                    end
                    3: begin
                        t.hour = 7'($urandom_range(24, 127));
                    end
                    4: begin
                        t.minute = 7'($urandom_range(60, 127));
                    end
                    default: begin
                        t.second = 7'($urandom_range(60, 127));
                    end
                endcase
            end else if (kind < 35) begin
                t.year         = 14'($urandom_range(0, 16383));
                t.month        = 7'($urandom_range(0, 127));
                t.day_of_month = 7'($urandom_range(0, 127));
                t.hour         = 7'($urandom_range(0, 127));
                t.minute       = 7'($urandom_range(0, 127));
                t.second       = 7'($urandom_range(0, 127));
            end
            dates_to_send.push_back(t);
        end
        total_dates = dates_to_send.size();

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        wait (beats_in == total_dates);
        wait (epochs_due.size() == 0);
        repeat (16) @(posedge aclk);

        $display("Summary: %0d dates checked, %0d converted and %0d rejected as out of range.",
                 results, converted, rejected);
        $display("Input was held off for %0d cycles; %0d mismatches seen.",
                 input_stalls, errors);
        if (errors == 0) begin
            $display("PASS calendar_to_unix_epoch");
        end else begin
            $display("FAIL calendar_to_unix_epoch");
        end
        $finish;
    end
endmodule

[sim.f]
+incdir+hdl
hdl/c2ue_pkg.sv
hdl/c2ue_check.sv
hdl/c2ue_days.sv
hdl/c2ue_secs.sv
hdl/calendar_to_unix_epoch.sv
tb/calendar_to_unix_epoch_tb.sv
